/* rtl/swr_pkg.sv */
// Shared types and constants for the sliding window receiver.
`timescale 1ns / 1ps

package swr_pkg;

   localparam int SEQ_W              = 32;
   localparam int WIN_W              = 7;
   localparam int SLIDE_W            = 7;
   localparam int SLOT_W             = 6;
   localparam int MAP_LIMIT          = 64;
   localparam int WINDOW_MAX_DEFAULT = 64;
   localparam int SCAN_CHUNK         = 16;

   typedef logic [SEQ_W-1:0]   seq_type;
   typedef logic [WIN_W-1:0]   win_type;
   typedef logic [SLIDE_W-1:0] slide_type;
   typedef logic [SLOT_W-1:0]  slot_type;

   localparam win_type WINDOW_RESET = win_type'(8);

   typedef struct packed {
      seq_type frame_seq;
      logic    checksum_ok;
   } req_type;

   typedef struct packed {
      logic      reply_send;
      logic      reply_is_nak;
      seq_type   reply_number;
      slide_type slide_count;
      logic      stored_early;
      slot_type  slot_index;
      logic      transfer_done;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic decide;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } status_type;

endpackage

/* rtl/swr_ctrl.sv */
// Sequencing state machine for the sliding window receiver.
`timescale 1ns / 1ps

module swr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output swr_pkg::cmd_type   cmd,
   input  swr_pkg::status_type sts
);

   typedef enum logic [2:0] {
      IDLE,
      CALC,
      DECIDE,
      SCAN,
      WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = CALC;
         end
         CALC: begin
            cmd.calc = 1'b1;
            state_in = DECIDE;
         end
         DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.need_scan ? SCAN : WRITE;
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = WRITE;
         end
         WRITE: begin
            cmd.commit = !rsp_valid_ff || rsp_ready;
            if (cmd.commit) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/swr_dpath.sv */
// Window state, frame classification, bitmap scan and result register.
`timescale 1ns / 1ps

module swr_dpath #(
   parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  swr_pkg::win_type    csr_data,
   input  swr_pkg::req_type    req_data,
   input  swr_pkg::cmd_type    cmd,
   output swr_pkg::status_type sts,
   output swr_pkg::rsp_type    rsp_data
);

   localparam int MAP_W = (WINDOW_MAX < swr_pkg::MAP_LIMIT) ? WINDOW_MAX : swr_pkg::MAP_LIMIT;
   localparam int IDX_W = $clog2(MAP_W);
   localparam int CHUNK = (MAP_W < swr_pkg::SCAN_CHUNK) ? MAP_W : swr_pkg::SCAN_CHUNK;
   localparam int CNT_W = $clog2(CHUNK);
   localparam swr_pkg::win_type W_LIM = swr_pkg::win_type'(MAP_W);

   // architectural state
   swr_pkg::win_type   window_ff;
   swr_pkg::seq_type   last_ff, last_in;
   logic [MAP_W-1:0]   map_ff, map_in;
   logic               finished_ff, finished_in;

   // per-frame working registers
   swr_pkg::seq_type   seq_ff;
   logic               ok_ff;
   logic [swr_pkg::SEQ_W:0] diff_ff;
   swr_pkg::seq_type   num_ff;
   logic               seq_zero_ff;
   logic               in_win_ff, next_ff, later_ff;
   swr_pkg::slide_type idx_ff;
   logic [MAP_W-1:0]   scan_map_ff;
   swr_pkg::slide_type count_ff;
   swr_pkg::rsp_type   rsp_ff, rsp_in;

   swr_pkg::win_type   w_eff;
   logic [MAP_W-1:0]   mask, masked;
   logic               in_win_c, next_c, later_c;
   logic [CHUNK-1:0]   chunk;
   logic               all_ones;
   logic [CNT_W-1:0]   trail;
   logic               accepted_ok, early_hit;

   always_comb begin
      if (window_ff == '0) w_eff = swr_pkg::win_type'(1);
      else if (window_ff > W_LIM) w_eff = W_LIM;
      else w_eff = window_ff;
      for (int i = 0; i < MAP_W; i++) begin
         mask[i] = (swr_pkg::win_type'(i) < w_eff);
      end
      masked = map_ff & mask;
   end

   assign in_win_c = !finished_ff &&
                     (diff_ff[swr_pkg::SEQ_W] || diff_ff <= (swr_pkg::SEQ_W+1)'(w_eff));
   assign next_c   = (diff_ff == (swr_pkg::SEQ_W+1)'(1));
   assign later_c  = !diff_ff[swr_pkg::SEQ_W] && (diff_ff > (swr_pkg::SEQ_W+1)'(1));

   assign chunk    = scan_map_ff[CHUNK-1:0];
   assign all_ones = &chunk;

   always_comb begin
      trail = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (!chunk[i]) trail = CNT_W'(i);
      end
   end

   assign sts.need_scan = in_win_c && ok_ff && next_c;
   assign sts.scan_last = !all_ones;

   assign accepted_ok = in_win_ff && ok_ff;
   assign early_hit   = !map_ff[idx_ff[IDX_W-1:0]];

   always_comb begin
      last_in     = last_ff;
      map_in      = map_ff;
      finished_in = finished_ff;
      if (accepted_ok && next_ff) begin
         map_in  = masked >> count_ff;
         last_in = last_ff + swr_pkg::SEQ_W'(count_ff);
      end else if (accepted_ok && later_ff) begin
         map_in[idx_ff[IDX_W-1:0]] = 1'b1;
      end
      if (accepted_ok && seq_zero_ff) finished_in = 1'b1;

      rsp_in.reply_send    = in_win_ff;
      rsp_in.reply_is_nak  = in_win_ff && !ok_ff;
      rsp_in.reply_number  = in_win_ff ? num_ff : '0;
      rsp_in.slide_count   = (accepted_ok && next_ff) ? count_ff : '0;
      rsp_in.stored_early  = accepted_ok && later_ff && early_hit;
      rsp_in.slot_index    = (accepted_ok && later_ff) ? idx_ff[swr_pkg::SLOT_W-1:0] : '0;
      rsp_in.transfer_done = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= swr_pkg::WINDOW_RESET;
         last_ff     <= '0;
         map_ff      <= '0;
         finished_ff <= 1'b0;
      end else begin
         if (csr_valid) window_ff <= csr_data;
         if (cmd.commit) begin
            last_ff     <= last_in;
            map_ff      <= map_in;
            finished_ff <= finished_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff <= req_data.frame_seq;
         ok_ff  <= req_data.checksum_ok;
      end
      if (cmd.calc) begin
         diff_ff     <= {1'b0, seq_ff} - {1'b0, last_ff};
         num_ff      <= ok_ff ? seq_ff + swr_pkg::seq_type'(1) : seq_ff;
         seq_zero_ff <= (seq_ff == '0);
      end
      if (cmd.decide) begin
         in_win_ff   <= in_win_c;
         next_ff     <= next_c;
         later_ff    <= later_c;
         idx_ff      <= diff_ff[swr_pkg::SLIDE_W-1:0] - swr_pkg::slide_type'(1);
         scan_map_ff <= masked >> 1;
         count_ff    <= swr_pkg::slide_type'(1);
      end
      if (cmd.scan) begin
         if (all_ones) begin
            count_ff    <= count_ff + swr_pkg::slide_type'(CHUNK);
            scan_map_ff <= scan_map_ff >> CHUNK;
         end else begin
            count_ff <= count_ff + swr_pkg::slide_type'(trail);
         end
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/sliding_window_receiver.sv */
// Top level of the sliding window receiver.
//
//   channel | ports             | direction | moves
//   --------+-------------------+-----------+---------------------------------
//   req     | req_valid/ready   | in        | one frame: sequence, checksum ok
//   rsp     | rsp_valid/ready   | out       | one reply per frame
//   csr     | csr_valid/ready   | in        | window size (ready outside reset)
//
// A frame steps through accept, difference, classify and write; the result register
// loads in the write step and the next frame can follow in the cycle after it.
// A good in-order frame adds 1 to 4 scan steps of 16 bitmap bits before the write.
// Synchronous reset clears the window state; window size returns to 8.
// The result register holds a reply until taken; the next frame is accepted
// meanwhile, and its write waits for rsp_ready.
`timescale 1ns / 1ps

module sliding_window_receiver #(
   parameter int WINDOW_MAX = swr_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  swr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output swr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  swr_pkg::win_type csr_data
);

   swr_pkg::cmd_type    cmd;
   swr_pkg::status_type sts;

   assign csr_ready = !reset;

   swr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   swr_dpath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/swr_checker.sv */
// Port-level assertions for the sliding window receiver, bound to the top level.
`timescale 1ns / 1ps

module swr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input swr_pkg::rsp_type rsp_data
);

   logic done_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_data.transfer_done) begin
         done_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("reply changed while stalled");

   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second frame taken while busy");

   a_no_reply_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reply_send |->
         !rsp_data.reply_is_nak && rsp_data.reply_number == '0 &&
         rsp_data.slide_count == '0 && !rsp_data.stored_early && rsp_data.slot_index == '0)
      else $error("dropped frame carries reply fields");

   a_nak_no_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reply_is_nak |->
         rsp_data.reply_send && rsp_data.slide_count == '0 && !rsp_data.stored_early)
      else $error("NAK with window update");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_seen_ff |->
         rsp_data.transfer_done && !rsp_data.reply_send && rsp_data.slide_count == '0)
      else $error("activity after final frame");

endmodule

bind sliding_window_receiver swr_checker u_swr_checker (.*);
